>>> rtl/i2cbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
`default_nettype none
package i2cbe_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);

  // Command codes
  localparam logic [2:0] CMD_START     = 3'd0;
  localparam logic [2:0] CMD_STOP      = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_READ_ACK  = 3'd3;
  localparam logic [2:0] CMD_READ_NACK = 3'd4;
  localparam logic [2:0] CMD_IDLE      = 3'd7;

  // Phases within one bit slot
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_HOLD  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_POLL_LIMIT = 1'b0;
  localparam logic CFG_TICKS      = 1'b1;

  localparam logic [7:0]  POLL_LIMIT_RST = 8'd250;
  localparam logic [15:0] TICKS_RST      = 16'd1;
  localparam logic [7:0]  MSB_MASK       = 8'h80;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] write_byte;
    logic       sda_level;
  } in_word_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
    logic       ack_timeout;
  } out_word_t;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [1:0]           phase;
    logic [15:0]          tick;
    logic [BIT_CNT_W-1:0] bit_cnt;
    logic [7:0]           shift;
    logic [7:0]           poll;
    logic                 scl;
    logic                 sda;
    logic [7:0]           rdata;
    logic                 ack_seen;
    logic                 ack_to;
  } eng_state_t;

  localparam eng_state_t STATE_RST = '{
    cmd: CMD_IDLE, phase: PH_SETUP, tick: '0, bit_cnt: '0, shift: '0, poll: '0,
    scl: 1'b1, sda: 1'b1, rdata: '0, ack_seen: 1'b0, ack_to: 1'b0
  };

endpackage
`default_nettype wire

>>> rtl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: input register, engine state, result register.
//
// Each input word is one timing tick of the bus waveform: an optional command
// (start, stop, write byte, read with ACK, read with NACK), the sampled SDA
// level and the byte to write. Each accepted word yields exactly one result
// word carrying the open-drain SCL/SDA drive (1 = released), busy, done, the
// last read byte and the ACK status of the last write.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// out_valid comes from the result register, which takes each result from the
// input register through the combinational state update; one word per cycle is
// sustained while the receiver does not stall.
// When the receiver stalls, the result register holds; the input register
// still takes a word if it is empty, and in_stall rises while it holds one.
// cfg_index 0 is the ACK poll limit, 1 the ticks per phase of a bit; write
// them only while the engine is idle.
// Synchronous reset (rst_n low) empties both registers, puts the engine idle
// with SCL and SDA released, and loads poll limit 250 and ticks per phase 1.
`default_nettype none
module i2c_master_bit_engine
  import i2cbe_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire in_word_t in_word,
  output logic       out_valid,
  input  wire        out_stall,
  output out_word_t  out_word,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [15:0] cfg_wdata
);

  logic       in_valid_r;
  in_word_t   in_word_r;
  eng_state_t state_r;
  eng_state_t state_nxt;
  logic       out_valid_r;
  out_word_t  out_word_r;
  out_word_t  res_nxt;
  logic [7:0] poll_limit_r;
  logic [15:0] tpp_r;
  logic       adv;
  logic       fire;

  // Pipeline advance: result slot free or being drained
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && adv;
  assign in_stall = in_valid_r && !adv;

  i2cbe_step u_step (
    .cur_state       (state_r),
    .word_i          (in_word_r),
    .poll_limit      (poll_limit_r),
    .ticks_per_phase (tpp_r),
    .next_state      (state_nxt),
    .res_o           (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
  end

  // Engine state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        state_r <= state_nxt;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
    end
    if (fire) begin
      out_word_r <= res_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= POLL_LIMIT_RST;
      tpp_r        <= TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLL_LIMIT: poll_limit_r <= cfg_wdata[7:0];
        CFG_TICKS:      tpp_r        <= cfg_wdata;
        default:        tpp_r        <= tpp_r;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

>>> rtl/i2cbe_step.sv
// Next-state and result logic for one tick of the I2C bit engine.
`default_nettype none
module i2cbe_step
  import i2cbe_pkg::*;
(
  input  wire eng_state_t cur_state,
  input  wire in_word_t   word_i,
  input  wire [7:0]       poll_limit,
  input  wire [15:0]      ticks_per_phase,
  output eng_state_t      next_state,
  output out_word_t       res_o
);

  logic [15:0] tpp_eff;
  logic [16:0] tick_plus;
  logic        is_read;
  logic        in_data;
  logic        busy;
  logic        done;
  logic        scl_drv;
  logic        sda_drv;

  always_comb begin
    next_state = cur_state;
    busy       = 1'b0;
    done       = 1'b0;
    scl_drv    = cur_state.scl;
    sda_drv    = cur_state.sda;

    // Launch a command when idle
    if (cur_state.cmd == CMD_IDLE && word_i.cmd_valid &&
        (word_i.mode inside {[CMD_START:CMD_READ_NACK]})) begin
      next_state.cmd      = word_i.mode;
      next_state.phase    = PH_SETUP;
      next_state.tick     = '0;
      next_state.bit_cnt  = '0;
      next_state.poll     = '0;
      next_state.shift    = (word_i.mode == CMD_WRITE) ? word_i.write_byte : 8'd0;
      next_state.ack_seen = 1'b0;
      next_state.ack_to   = 1'b0;
    end

    tpp_eff   = (ticks_per_phase == 16'd0) ? 16'd1 : ticks_per_phase;
    tick_plus = {1'b0, next_state.tick} + 17'd1;
    is_read   = (next_state.cmd == CMD_READ_ACK) || (next_state.cmd == CMD_READ_NACK);
    in_data   = next_state.bit_cnt < BIT_CNT_W'(BITS_PER_BYTE);

    if (next_state.cmd != CMD_IDLE) begin
      busy = 1'b1;

      // Line drive for this phase
      case (next_state.cmd)
        CMD_START: begin
          scl_drv = (next_state.phase == PH_SETUP) || (next_state.phase == PH_HIGH);
          sda_drv = (next_state.phase == PH_SETUP);
        end
        CMD_STOP: begin
          scl_drv = (next_state.phase != PH_SETUP);
          sda_drv = (next_state.phase == PH_HOLD);
        end
        CMD_WRITE: begin
          scl_drv = (next_state.phase == PH_HIGH);
          sda_drv = in_data ? ((next_state.shift & MSB_MASK) != 8'd0) : 1'b1;
        end
        default: begin
          scl_drv = (next_state.phase == PH_HIGH);
          sda_drv = in_data ? 1'b1 : (next_state.cmd == CMD_READ_NACK);
        end
      endcase
      next_state.scl = scl_drv;
      next_state.sda = sda_drv;

      if (next_state.cmd == CMD_WRITE && !in_data && next_state.phase == PH_HIGH) begin
        // ACK slot: poll SDA every tick
        if (!word_i.sda_level) begin
          next_state.ack_seen = 1'b1;
          next_state.phase    = PH_HOLD;
          next_state.tick     = '0;
        end else if (next_state.poll == poll_limit) begin
          next_state.ack_to  = 1'b1;
          next_state.cmd     = CMD_STOP;
          next_state.phase   = PH_SETUP;
          next_state.tick    = '0;
          next_state.bit_cnt = '0;
        end else begin
          next_state.poll = next_state.poll + 8'd1;
        end
      end else if (tick_plus < {1'b0, tpp_eff}) begin
        next_state.tick = tick_plus[15:0];
      end else begin
        next_state.tick = '0;
        // Sample read data at the end of the high phase
        if (is_read && in_data && next_state.phase == PH_HIGH) begin
          next_state.shift = {next_state.shift[6:0], word_i.sda_level};
        end
        if (next_state.phase != PH_HOLD) begin
          next_state.phase = next_state.phase + 2'd1;
        end else begin
          next_state.phase = PH_SETUP;
          if (next_state.cmd == CMD_START || next_state.cmd == CMD_STOP) begin
            next_state.cmd     = CMD_IDLE;
            next_state.bit_cnt = '0;
            done               = 1'b1;
          end else if (in_data) begin
            if (next_state.cmd == CMD_WRITE) begin
              next_state.shift = {next_state.shift[6:0], 1'b0};
            end
            next_state.bit_cnt = next_state.bit_cnt + BIT_CNT_W'(1);
            if (is_read && next_state.bit_cnt == BIT_CNT_W'(BITS_PER_BYTE)) begin
              next_state.rdata = next_state.shift;
            end
          end else begin
            next_state.cmd     = CMD_IDLE;
            next_state.bit_cnt = '0;
            done               = 1'b1;
          end
        end
      end
    end

    res_o.scl_release = next_state.scl;
    res_o.sda_release = next_state.sda;
    res_o.busy_res    = busy;
    res_o.done_res    = done;
    res_o.read_byte   = next_state.rdata;
    res_o.ack_seen    = next_state.ack_seen;
    res_o.ack_timeout = next_state.ack_to;
  end

endmodule
`default_nettype wire

>>> verif/i2cbe_line_checker.sv
// Line checker for the I2C master bit engine: predicts each result word and compares it.
`timescale 1ns / 1ps
module i2cbe_line_checker
  import i2cbe_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_stall,
  input  in_word_t   in_word,
  input  wire        out_valid,
  input  wire        out_stall,
  input  out_word_t  out_word,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [15:0] cfg_wdata,
  output int         fail_count,
  output int         words_pending,
  output logic       engine_idle
);

  // Predicted engine state
  logic [2:0]  eng_cmd;
  int          eng_phase;
  int          eng_tick;
  int          eng_bits;
  logic [7:0]  eng_shift;
  logic [7:0]  eng_poll;
  logic [7:0]  eng_rdata;
  logic        eng_scl;
  logic        eng_sda;
  logic        eng_seen;
  logic        eng_tout;

  // Register copies
  logic [7:0]  poll_limit;
  logic [15:0] phase_ticks;

  // Line and status words still owed by the block, oldest first
  out_word_t   predicted_ticks[$];
  out_word_t   pred;
  out_word_t   oldest;

  assign engine_idle = (eng_cmd == CMD_IDLE);

  // One timing tick of the engine
  task automatic advance_engine(input in_word_t w, output out_word_t r);
    int   tpp;
    logic rd;
    logic in_data;
    logic busy;
    logic done;
    busy = 1'b0;
    done = 1'b0;
    if (eng_cmd == CMD_IDLE && w.cmd_valid && w.mode <= CMD_READ_NACK) begin
      eng_cmd   = w.mode;
      eng_phase = 0;
      eng_tick  = 0;
      eng_bits  = 0;
      eng_poll  = 8'h00;
      eng_shift = (w.mode == CMD_WRITE) ? w.write_byte : 8'h00;
      eng_seen  = 1'b0;
      eng_tout  = 1'b0;
    end
    if (eng_cmd != CMD_IDLE) begin
      busy    = 1'b1;
      tpp     = (phase_ticks == 16'd0) ? 1 : int'(phase_ticks);
      rd      = (eng_cmd == CMD_READ_ACK) || (eng_cmd == CMD_READ_NACK);
      in_data = eng_bits < BITS_PER_BYTE;
      // line drive comes from the state at the start of the tick
      case (eng_cmd)
        CMD_START: begin
          eng_scl = eng_phase < 2;
          eng_sda = eng_phase == 0;
        end
        CMD_STOP: begin
          eng_scl = eng_phase > 0;
          eng_sda = eng_phase == 2;
        end
        CMD_WRITE: begin
          eng_scl = eng_phase == 1;
          eng_sda = in_data ? eng_shift[7] : 1'b1;
        end
        default: begin
          eng_scl = eng_phase == 1;
          eng_sda = in_data ? 1'b1 : (eng_cmd == CMD_READ_NACK);
        end
      endcase
      if (eng_cmd == CMD_WRITE && !in_data && eng_phase == 1) begin
        // ACK slot with SCL high: poll SDA every tick
        if (!w.sda_level) begin
          eng_seen  = 1'b1;
          eng_phase = 2;
          eng_tick  = 0;
        end else if (eng_poll == poll_limit) begin
          eng_tout  = 1'b1;
          eng_cmd   = CMD_STOP;
          eng_phase = 0;
          eng_tick  = 0;
          eng_bits  = 0;
        end else begin
          eng_poll++;
        end
      end else if (eng_tick + 1 < tpp) begin
        eng_tick++;
      end else begin
        eng_tick = 0;
        if (rd && in_data && eng_phase == 1)
          eng_shift = {eng_shift[6:0], w.sda_level};
        if (eng_phase < 2) begin
          eng_phase++;
        end else begin
          eng_phase = 0;
          if (eng_cmd == CMD_START || eng_cmd == CMD_STOP || !in_data) begin
            eng_cmd  = CMD_IDLE;
            eng_tick = 0;
            eng_bits = 0;
            done     = 1'b1;
          end else begin
            if (eng_cmd == CMD_WRITE)
              eng_shift = eng_shift << 1;
            eng_bits++;
            if (rd && eng_bits == BITS_PER_BYTE)
              eng_rdata = eng_shift;
          end
        end
      end
    end
    r = '{scl_release: eng_scl, sda_release: eng_sda, busy_res: busy, done_res: done,
          read_byte: eng_rdata, ack_seen: eng_seen, ack_timeout: eng_tout};
  endtask

  task automatic note_failure(input string what, input out_word_t exp, input out_word_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected scl %b sda %b busy %b done %b byte %h ack %b tmo %b",
               $realtime, what, exp.scl_release, exp.sda_release, exp.busy_res,
               exp.done_res, exp.read_byte, exp.ack_seen, exp.ack_timeout);
      $display("    got scl %b sda %b busy %b done %b byte %h ack %b tmo %b",
               got.scl_release, got.sda_release, got.busy_res, got.done_res,
               got.read_byte, got.ack_seen, got.ack_timeout);
    end
  endtask

  initial begin
    fail_count    = 0;
    words_pending = 0;
    eng_cmd       = CMD_IDLE;
  end

  // Watch both channels and the register port on every rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      eng_cmd     = CMD_IDLE;
      eng_phase   = 0;
      eng_tick    = 0;
      eng_bits    = 0;
      eng_shift   = 8'h00;
      eng_poll    = 8'h00;
      eng_rdata   = 8'h00;
      eng_scl     = 1'b1;
      eng_sda     = 1'b1;
      eng_seen    = 1'b0;
      eng_tout    = 1'b0;
      poll_limit  = POLL_LIMIT_RST;
      phase_ticks = TICKS_RST;
      predicted_ticks.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_POLL_LIMIT)
          poll_limit = cfg_wdata[7:0];
        else
          phase_ticks = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        advance_engine(in_word, pred);
        predicted_ticks.push_back(pred);
      end
      if (out_valid && !out_stall) begin
        if (predicted_ticks.size() == 0) begin
          note_failure("word with nothing expected", '0, out_word);
        end else begin
          oldest = predicted_ticks.pop_front();
          if (out_word.scl_release !== oldest.scl_release ||
              out_word.sda_release !== oldest.sda_release ||
              out_word.busy_res    !== oldest.busy_res    ||
              out_word.done_res    !== oldest.done_res    ||
              out_word.read_byte   !== oldest.read_byte   ||
              out_word.ack_seen    !== oldest.ack_seen    ||
              out_word.ack_timeout !== oldest.ack_timeout)
            note_failure("wrong word", oldest, out_word);
        end
      end
    end
    words_pending = predicted_ticks.size();
  end

endmodule

>>> verif/testbench.sv
// Top of the I2C master bit engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench
  import i2cbe_pkg::*;
;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD   = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  int          fail_count;
  int          words_pending;
  logic        engine_idle;

  int          cycle_count;
  int          words_sent;
  int          burst_left;
  int          steady_left;
  int          hold_reqs;
  int          cur_limit;
  int          cur_tpp;

  i2c_master_bit_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  i2cbe_line_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .engine_idle   (engine_idle)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run-away guard
  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("i2c_master_bit_engine: mismatch");
    $finish;
  end

  // Receiver: random stall patterns, plus a long hold when asked for
  initial begin : receiver
    int holds_done;
    int hold_left;
    int pat_left;
    int pat_style;
    holds_done = 0;
    hold_left  = 0;
    pat_left   = 0;
    pat_style  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done < hold_reqs) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat_left  = $urandom_range(1, 40);
          pat_style = $urandom_range(0, 2);
        end
        pat_left--;
        case (pat_style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one word and hold it until taken; bursts with random gaps
  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_left > 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    words_sent++;
    if (steady_left > 0)
      steady_left--;
  endtask

  // Idle ticks with SDA low until the engine has nothing in progress
  task automatic flush_engine();
    while (!engine_idle)
      send_word(in_word_t'{1'b0, CMD_IDLE, 8'h00, 1'b0});
  endtask

  // Let the engine finish and every owed word come out
  task automatic settle();
    flush_engine();
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input int limit, input int ticks);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POLL_LIMIT;
    cfg_wdata <= 16'(limit);
    @(negedge clk);
    cfg_index <= CFG_TICKS;
    cfg_wdata <= 16'(ticks);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_limit = limit;
    cur_tpp   = ticks;
  endtask

  // One command plus the ticks it runs for. hi is the number of high SDA
  // samples in a write's ACK slot; beyond the limit the write times out.
  // fill sets SDA elsewhere: 0 low, 1 high, 2 random.
  task automatic run_command(input logic [2:0] mode, input logic [7:0] data,
                             input int hi, input int fill);
    int       eff;
    int       dur;
    int       poll_at;
    int       i;
    logic     timeout;
    in_word_t w;
    eff     = (cur_tpp == 0) ? 1 : cur_tpp;
    poll_at = 25 * eff;
    timeout = (mode == CMD_WRITE) && (hi > cur_limit);
    if (timeout)
      hi = cur_limit + 1;
    case (mode)
      CMD_START, CMD_STOP:         dur = 3 * eff;
      CMD_WRITE:                   dur = timeout ? poll_at + hi + 3 * eff
                                                 : poll_at + hi + 1 + eff;
      CMD_READ_ACK, CMD_READ_NACK: dur = 27 * eff;
      default:                     dur = 1;
    endcase
    for (i = 0; i < dur; i++) begin
      // later ticks sometimes offer a command too; the busy engine drops it
      w.cmd_valid  = (i == 0) ? 1'b1 : ($urandom_range(0, 7) == 0);
      w.mode       = (i == 0) ? mode : 3'($urandom_range(0, 7));
      w.write_byte = (i == 0) ? data : 8'($urandom);
      if (mode == CMD_WRITE && i >= poll_at && i < poll_at + hi)
        w.sda_level = 1'b1;
      else if (mode == CMD_WRITE && i == poll_at + hi && !timeout)
        w.sda_level = 1'b0;
      else
        w.sda_level = (fill == 2) ? 1'($urandom) : 1'(fill);
      send_word(w);
    end
  endtask

  // Mostly framed transfers with random content, some loose words
  task automatic random_traffic(input int budget);
    int         goal;
    int         n;
    int         k;
    int         hi;
    logic [2:0] op;
    goal = words_sent + budget;
    while (words_sent < goal) begin
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n)
          send_word(in_word_t'{1'($urandom), 3'($urandom), 8'($urandom), 1'($urandom)});
        flush_engine();
      end else begin
        if ($urandom_range(0, 9) != 0)
          run_command(CMD_START, 8'($urandom), 0, 2);
        n = $urandom_range(1, 3);
        repeat (n) begin
          k  = $urandom_range(0, 9);
          op = (k < 6) ? CMD_WRITE : ((k < 8) ? CMD_READ_ACK : CMD_READ_NACK);
          k  = $urandom_range(0, 9);
          if (k < 2 && cur_limit <= 16)
            hi = cur_limit + 1;
          else if (k == 2)
            hi = $urandom_range(4, 20);
          else
            hi = $urandom_range(0, 3);
          run_command(op, 8'($urandom), hi, 2);
        end
        if ($urandom_range(0, 9) != 0)
          run_command(CMD_STOP, 8'($urandom), 0, 2);
      end
    end
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int m;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_POLL_LIMIT;
    cfg_wdata   = '0;
    words_sent  = 0;
    burst_left  = 0;
    steady_left = 0;
    hold_reqs   = 0;
    cur_limit   = int'(POLL_LIMIT_RST);
    cur_tpp     = int'(TICKS_RST);
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset settings: framing, data extremes, reads, ignored codes
    run_command(CMD_START, 8'h00, 0, 2);
    run_command(CMD_WRITE, 8'hFF, 0, 2);       // ACK on the first poll
    run_command(CMD_WRITE, 8'h00, 2, 2);
    run_command(CMD_WRITE, 8'h5A, 251, 2);     // poll runs out, stop follows
    run_command(CMD_START, 8'hFF, 0, 2);
    run_command(CMD_READ_ACK, 8'h00, 0, 1);    // all ones
    run_command(CMD_READ_NACK, 8'hFF, 0, 0);   // all zeros
    run_command(CMD_READ_ACK, 8'h3C, 0, 2);
    run_command(CMD_STOP, 8'h00, 0, 2);
    for (m = 5; m <= 7; m++)
      run_command(3'(m), 8'hFF, 0, 2);         // undefined modes stay idle
    run_command(CMD_STOP, 8'h81, 0, 2);
    random_traffic(30);

    // Zero poll limit, zero phase length
    configure(0, 0);
    run_command(CMD_WRITE, 8'hC3, 1, 2);       // first high sample times out
    run_command(CMD_WRITE, 8'h3C, 0, 2);
    random_traffic(30);

    // Widest poll limit, longer phases; the receiver holds off a while
    configure(255, 2);
    hold_reqs++;
    steady_left = 3 * LONG_HOLD;
    random_traffic(60);

    configure(3, 1);
    random_traffic(30);

    // Longer phase, one start condition only
    configure($urandom_range(0, 255), 12);
    run_command(CMD_START, 8'h00, 0, 2);

    settle();
    if (fail_count == 0)
      $display("i2c_master_bit_engine: match");
    else
      $display("i2c_master_bit_engine: mismatch");
    $finish;
  end

endmodule

>>> i2c_master_bit_engine.f
rtl/i2cbe_pkg.sv
rtl/i2cbe_step.sv
rtl/i2c_master_bit_engine.sv
verif/i2cbe_line_checker.sv
verif/testbench.sv
